FILE: design/pbt_pkg.sv
// Package for the page-to-row bitmap transpose block.
// Holds frame geometry constants and the types shared by the cells and the top level.
// Depends on nothing.
package pbt_pkg;

   // Frame geometry of the page-organized source.
   localparam int SRC_WIDTH = 128;
   localparam int SRC_PAGES = 32;
   localparam int BLOCK = 8;
   localparam int GROUPS = SRC_WIDTH / BLOCK;
   localparam int ROWS = BLOCK;
   localparam int COL_CELLS = BLOCK - 1;

   localparam int BYTE_W = 8;
   localparam int INDEX_W = 12;
   localparam int SLOT_W = $clog2(BLOCK);
   localparam int GROUP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAGE_W = (SRC_PAGES > 1) ? $clog2(SRC_PAGES) : 1;

   // Address step from one page of eight pixel rows to the next, modulo the index range.
   localparam logic [INDEX_W-1:0] PAGE_STEP = INDEX_W'((BLOCK * GROUPS) % (1 << INDEX_W));
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCK - 1);
   localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(GROUPS - 1);
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(SRC_PAGES - 1);

   // Position of the next source byte within the frame.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [GROUP_W-1:0] group;
      logic [PAGE_W-1:0] page;
      logic [INDEX_W-1:0] base;
      logic last_block;
   } pos_type;

   // One result row held in a row cell.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0] data;
      logic block_last;
      logic frame_last;
   } row_type;

   // Controls broadcast to every row cell.
   typedef struct packed {
      logic load;
      logic shift;
   } row_ctl_type;

endpackage

FILE: design/pbt_col_cell.sv
// Column cell of the collect chain: holds one source byte of the block being gathered.
// Depends on pbt_pkg for the byte width.
module pbt_col_cell (
   input  logic clock,
   input  logic shift_en,
   input  logic [pbt_pkg::BYTE_W-1:0] d_in,
   output logic [pbt_pkg::BYTE_W-1:0] q
);

   logic [pbt_pkg::BYTE_W-1:0] byte_ff;
   logic [pbt_pkg::BYTE_W-1:0] byte_in;

   // Take the neighbor's byte on every accepted request.
   always_comb begin
      byte_in = shift_en ? d_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q = byte_ff;

endmodule

FILE: design/pbt_row_cell.sv
// Row cell of the output chain: holds one transposed row with its address and flags.
// Depends on pbt_pkg for row_type and row_ctl_type.
module pbt_row_cell (
   input  logic clock,
   input  logic reset,
   input  pbt_pkg::row_ctl_type ctl,
   input  pbt_pkg::row_type load_row,
   input  pbt_pkg::row_type next_row,
   input  logic next_valid,
   output pbt_pkg::row_type row_q,
   output logic valid_q
);

   pbt_pkg::row_type row_ff;
   pbt_pkg::row_type row_in;
   logic valid_ff;
   logic valid_in;

   // A new block loads every cell at once; otherwise rows move one cell toward the output.
   always_comb begin
      row_in = row_ff;
      valid_in = valid_ff;
      if (ctl.load) begin
         row_in = load_row;
         valid_in = 1'b1;
      end else if (ctl.shift) begin
         row_in = next_row;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      row_ff <= row_in;
   end

   assign row_q = row_ff;
   assign valid_q = valid_ff;

endmodule

FILE: design/pbt_position.sv
// Frame position counter: slot within the block, column group, page and page base address.
// Depends on pbt_pkg for pos_type and the frame geometry.
module pbt_position (
   input  logic clock,
   input  logic reset,
   input  logic req_accept,
   input  logic req_frame_start,
   output pbt_pkg::pos_type cur
);

   pbt_pkg::pos_type pos_ff;
   pbt_pkg::pos_type pos_in;

   // A frame start places this request at column 0 of page 0.
   always_comb begin
      cur = pos_ff;
      if (req_frame_start) begin
         cur = '0;
      end
      cur.last_block = (cur.group == pbt_pkg::LAST_GROUP) && (cur.page == pbt_pkg::LAST_PAGE);
   end

   // Advance past the accepted request, wrapping at the end of the frame.
   always_comb begin
      pos_in = cur;
      pos_in.last_block = 1'b0;
      if (cur.slot != pbt_pkg::LAST_SLOT) begin
         pos_in.slot = cur.slot + 1'b1;
      end else begin
         pos_in.slot = '0;
         if (cur.group != pbt_pkg::LAST_GROUP) begin
            pos_in.group = cur.group + 1'b1;
         end else begin
            pos_in.group = '0;
            if (cur.page != pbt_pkg::LAST_PAGE) begin
               pos_in.page = cur.page + 1'b1;
               pos_in.base = cur.base + pbt_pkg::PAGE_STEP;
            end else begin
               pos_in.page = '0;
               pos_in.base = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_accept) begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: design/page_to_row_bitmap_transpose.sv
// Page-to-row bitmap transpose: top level with the collect chain and the output row chain.
// Depends on pbt_pkg, pbt_position, pbt_col_cell and pbt_row_cell.
//
// Use: source bytes of a page-organized 1-bit frame enter on the req_ channel in raster
// order, one per request; req_frame_start marks column 0 of page 0. Each group of eight
// requests forms an 8x8 block. The first seven bytes travel down a chain of seven column
// cells; the eighth request transposes the chain into eight row cells at once.
// The row cells then hand one row a cycle to the rsp_ channel, row 0 first, with the
// destination address, a flag on the eighth row and a flag on the frame's final row.
// The first row of a block is shown in the cycle after its eighth request is taken.
// Throughput: one request and one result per cycle sustained while rsp_stall is low; the
// only hold-off is the eighth request of a block, which stalls until the row chain is
// empty or its last row is being taken. Other requests are taken while rows still drain.
// A stalled result holds its row; the chain waits and the next block waits behind it.
// Reset empties the row chain and returns the position to column 0 of page 0; bytes
// already collected are dropped.
module page_to_row_bitmap_transpose (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [pbt_pkg::BYTE_W-1:0] req_column_bits,
   input  logic req_frame_start,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [pbt_pkg::INDEX_W-1:0] rsp_dst_index,
   output logic [pbt_pkg::BYTE_W-1:0] rsp_row_bits,
   output logic rsp_block_last,
   output logic rsp_frame_last
);

   pbt_pkg::pos_type cur;
   logic req_accept;
   logic block_done;
   logic chain_free;
   logic [pbt_pkg::BYTE_W-1:0] col_q [pbt_pkg::COL_CELLS];
   logic [pbt_pkg::BYTE_W-1:0] blk [pbt_pkg::BLOCK];
   pbt_pkg::row_type load_rows [pbt_pkg::ROWS];
   pbt_pkg::row_type row_q [pbt_pkg::ROWS];
   logic valid_q [pbt_pkg::ROWS];
   pbt_pkg::row_ctl_type ctl;

   // Position within the frame.
   pbt_position u_position (
      .clock(clock),
      .reset(reset),
      .req_accept(req_accept),
      .req_frame_start(req_frame_start),
      .cur(cur)
   );

   // The row chain can take a block when empty or when its last row leaves now.
   assign chain_free = !valid_q[0] || (!valid_q[1] && !rsp_stall);
   assign req_stall = (cur.slot == pbt_pkg::LAST_SLOT) && !chain_free;
   assign req_accept = req_valid && !req_stall;
   assign block_done = req_accept && (cur.slot == pbt_pkg::LAST_SLOT);

   // Collect chain: each accepted request enters the top cell and moves every byte down.
   for (genvar c = 0; c < pbt_pkg::COL_CELLS; c++) begin : g_col
      if (c == pbt_pkg::COL_CELLS - 1) begin : g_top
         pbt_col_cell u_cell (
            .clock(clock),
            .shift_en(req_accept),
            .d_in(req_column_bits),
            .q(col_q[c])
         );
      end else begin : g_mid
         pbt_col_cell u_cell (
            .clock(clock),
            .shift_en(req_accept),
            .d_in(col_q[c+1]),
            .q(col_q[c])
         );
      end
   end

   // Transpose the block: row r takes bit r of each column byte, with its address.
   always_comb begin
      for (int i = 0; i < pbt_pkg::BLOCK; i++) begin
         blk[i] = (i == pbt_pkg::BLOCK - 1) ? req_column_bits : col_q[i % pbt_pkg::COL_CELLS];
      end
      for (int r = 0; r < pbt_pkg::ROWS; r++) begin
         for (int i = 0; i < pbt_pkg::BLOCK; i++) begin
            load_rows[r].data[i] = blk[i][r];
         end
         load_rows[r].index = cur.base + pbt_pkg::INDEX_W'(r * pbt_pkg::GROUPS)
                              + pbt_pkg::INDEX_W'(cur.group);
         load_rows[r].block_last = (r == pbt_pkg::ROWS - 1);
         load_rows[r].frame_last = (r == pbt_pkg::ROWS - 1) && cur.last_block;
      end
   end

   // Row chain controls.
   always_comb begin
      ctl.load = block_done;
      ctl.shift = valid_q[0] && !rsp_stall;
   end

   // Row chain: cell 0 faces the result channel, rows move toward it.
   for (genvar r = 0; r < pbt_pkg::ROWS; r++) begin : g_row
      if (r == pbt_pkg::ROWS - 1) begin : g_end
         pbt_row_cell u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(ctl),
            .load_row(load_rows[r]),
            .next_row('0),
            .next_valid(1'b0),
            .row_q(row_q[r]),
            .valid_q(valid_q[r])
         );
      end else begin : g_mid
         pbt_row_cell u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(ctl),
            .load_row(load_rows[r]),
            .next_row(row_q[r+1]),
            .next_valid(valid_q[r+1]),
            .row_q(row_q[r]),
            .valid_q(valid_q[r])
         );
      end
   end

   assign rsp_valid = valid_q[0];
   assign rsp_dst_index = row_q[0].index;
   assign rsp_row_bits = row_q[0].data;
   assign rsp_block_last = row_q[0].block_last;
   assign rsp_frame_last = row_q[0].frame_last;

   // A finished block always shows a result in the next cycle.
   a_block_shows: assert property (@(posedge clock) disable iff (reset)
      block_done |=> rsp_valid)
      else $error("completed block did not present a result");

   // The row flagged as the block's last is the only row left in the chain.
   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_last) |-> !valid_q[1])
      else $error("block_last row is not the final row in the chain");

   // The frame's last row is also its block's last row.
   a_frame_in_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_block_last)
      else $error("frame_last without block_last");

   // Valid rows are packed toward the output cell.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      valid_q[1] |-> valid_q[0])
      else $error("gap in the row chain");

endmodule
